@@ rtl/core/macp_pkg.sv @@
`default_nettype none

package macp_pkg;

    localparam int WINDOW_MAX = 256;
    localparam int PRICE_W    = 32;
    localparam int CFG_W      = 9;
    localparam int ADDR_W     = $clog2(WINDOW_MAX);
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W      = 64;
    localparam int SCORE_W    = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(5);
    localparam int SCORE_BASE = 1000;
    localparam logic [6:0] GAIN_MUL = 7'd100;
    localparam int GAIN_SHIFT = 8;

    typedef enum logic [1:0] {
        POS_FLAT  = 2'd0,
        POS_LONG  = 2'd1,
        POS_SHORT = 2'd2
    } t_pos;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               last_bar;
    } t_item;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [1:0]                final_position;
        logic                      too_short;
        logic                      saturated;
    } t_result;

    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (int'(v) > WINDOW_MAX) begin
            r = LEN_W'(WINDOW_MAX);
        end else begin
            r = LEN_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/macp_if.sv @@
`default_nettype none

interface macp_in_if;
    logic                          valid;
    logic                          ready;
    logic [macp_pkg::PRICE_W-1:0]  price;
    logic                          last_bar;

    modport source (output valid, output price, output last_bar, input ready);
    modport sink (input valid, input price, input last_bar, output ready);
endinterface

interface macp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [macp_pkg::SCORE_W-1:0] score;
    logic [1:0]                          final_position;
    logic                                too_short;
    logic                                saturated;

    modport source (output valid, output score, output final_position, output too_short,
                    output saturated, input ready);
    modport sink (input valid, input score, input final_position, input too_short,
                  input saturated, output ready);
endinterface

`default_nettype wire

@@ rtl/core/macp_window_store.sv @@
`default_nettype none

module macp_window_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire macp_pkg::t_item               i_item,
    input  wire logic [macp_pkg::LEN_W-1:0]    i_len,
    output logic [macp_pkg::PRICE_W-1:0]       o_old
);

    localparam int CALC_W = macp_pkg::LEN_W + 1;

    logic [macp_pkg::PRICE_W-1:0] r_mem [macp_pkg::WINDOW_MAX];
    logic [macp_pkg::ADDR_W-1:0]  r_wp;
    logic [macp_pkg::ADDR_W-1:0]  n_wp;
    logic [macp_pkg::PRICE_W-1:0] r_old;
    logic [CALC_W-1:0]            rd_calc;
    logic [CALC_W-1:0]            rd_wrap;
    logic [macp_pkg::ADDR_W-1:0]  rd_addr;

    // oldest entry of the window, relative to the slot about to be written
    always_comb begin
        rd_calc = CALC_W'(r_wp) + CALC_W'(macp_pkg::WINDOW_MAX) - CALC_W'(i_len);
        rd_wrap = (rd_calc >= CALC_W'(macp_pkg::WINDOW_MAX))
                  ? rd_calc - CALC_W'(macp_pkg::WINDOW_MAX) : rd_calc;
        rd_addr = rd_wrap[macp_pkg::ADDR_W-1:0];
    end

    always_comb begin
        if (i_item.last_bar) begin
            n_wp = '0;
        end else if (r_wp == macp_pkg::ADDR_W'(macp_pkg::WINDOW_MAX - 1)) begin
            n_wp = '0;
        end else begin
            n_wp = r_wp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (i_accept) begin
            r_wp <= n_wp;
        end
    end

    // read returns the value held before a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_old <= r_mem[rd_addr];
            if (!i_item.last_bar) begin
                r_mem[r_wp] <= i_item.price;
            end
        end
    end

    assign o_old = r_old;

endmodule

`default_nettype wire

@@ rtl/core/macp_tracker.sv @@
`default_nettype none

module macp_tracker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire macp_pkg::t_item               i_item,
    input  wire logic [macp_pkg::PRICE_W-1:0]  i_old,
    input  wire logic [macp_pkg::LEN_W-1:0]    i_len,
    output macp_pkg::t_result                  o_result
);

    localparam int WIDE_W = macp_pkg::SCORE_W + 2;
    localparam int PROD_W = macp_pkg::PRICE_W + 7;
    localparam int GAIN_W = PROD_W - macp_pkg::GAIN_SHIFT;
    localparam int SCL_W  = macp_pkg::PRICE_W + macp_pkg::LEN_W;
    localparam logic signed [WIDE_W-1:0] S_MAX = WIDE_W'(64'sh7FFF_FFFF);
    localparam logic signed [WIDE_W-1:0] S_MIN = WIDE_W'(-64'sh8000_0000);

    logic [macp_pkg::SUM_W-1:0]   r_sum,     n_sum;
    logic [macp_pkg::LEN_W-1:0]   r_count,   n_count;
    macp_pkg::t_pos               r_pos,     n_pos;
    logic [macp_pkg::PRICE_W-1:0] r_entry,   n_entry;
    logic                         r_pending, n_pending;

    logic                         fill;
    logic [macp_pkg::SUM_W-1:0]   sum_base;
    logic [macp_pkg::SUM_W-1:0]   sum_next;
    logic [SCL_W-1:0]             scaled;
    macp_pkg::t_pos               dir;
    logic [macp_pkg::PRICE_W-1:0] entry_eff;
    logic                         neg;
    logic [macp_pkg::PRICE_W-1:0] mag;
    logic [PROD_W-1:0]            prod;
    logic [GAIN_W-1:0]            gain;
    logic signed [WIDE_W-1:0]     score_w;

    always_comb begin
        fill     = r_count < i_len;
        sum_base = fill ? r_sum : r_sum - macp_pkg::SUM_W'(i_old);
        sum_next = sum_base + macp_pkg::SUM_W'(i_item.price);
        scaled   = SCL_W'(i_item.price) * SCL_W'(i_len);
        if (macp_pkg::SUM_W'(scaled) > sum_next) begin
            dir = macp_pkg::POS_LONG;
        end else if (macp_pkg::SUM_W'(scaled) < sum_next) begin
            dir = macp_pkg::POS_SHORT;
        end else begin
            dir = macp_pkg::POS_FLAT;
        end
    end

    // open gain at the final price
    always_comb begin
        entry_eff = r_pending ? i_item.price : r_entry;
        if (r_pos == macp_pkg::POS_SHORT) begin
            neg = entry_eff < i_item.price;
            mag = neg ? i_item.price - entry_eff : entry_eff - i_item.price;
        end else begin
            neg = i_item.price < entry_eff;
            mag = neg ? entry_eff - i_item.price : i_item.price - entry_eff;
        end
        prod = PROD_W'(mag) * PROD_W'(macp_pkg::GAIN_MUL);
        gain = prod[PROD_W-1:macp_pkg::GAIN_SHIFT];
        score_w = neg ? WIDE_W'(macp_pkg::SCORE_BASE) - signed'(WIDE_W'(gain))
                      : WIDE_W'(macp_pkg::SCORE_BASE) + signed'(WIDE_W'(gain));
    end

    always_comb begin
        o_result = '0;
        if (!fill && r_pos != macp_pkg::POS_FLAT) begin
            o_result.final_position = r_pos;
            if (score_w > S_MAX) begin
                o_result.score     = S_MAX[macp_pkg::SCORE_W-1:0];
                o_result.saturated = 1'b1;
            end else if (score_w < S_MIN) begin
                o_result.score     = S_MIN[macp_pkg::SCORE_W-1:0];
                o_result.saturated = 1'b1;
            end else begin
                o_result.score = score_w[macp_pkg::SCORE_W-1:0];
            end
        end
        o_result.too_short = fill;
    end

    always_comb begin
        n_sum     = r_sum;
        n_count   = r_count;
        n_pos     = r_pos;
        n_entry   = r_entry;
        n_pending = r_pending;
        if (i_item.last_bar) begin
            n_sum     = '0;
            n_count   = '0;
            n_pos     = macp_pkg::POS_FLAT;
            n_entry   = '0;
            n_pending = 1'b0;
        end else begin
            if (r_pending) begin
                n_entry   = i_item.price;
                n_pending = 1'b0;
            end
            n_sum = sum_next;
            if (fill) begin
                if (macp_pkg::LEN_W'(r_count + 1'b1) == i_len) begin
                    n_pos = dir;
                    if (dir != macp_pkg::POS_FLAT) begin
                        n_pending = 1'b1;
                    end
                end
            end else if (dir != macp_pkg::POS_FLAT && dir != r_pos) begin
                n_pos     = dir;
                n_pending = 1'b1;
            end
            if (r_count < macp_pkg::LEN_W'(macp_pkg::WINDOW_MAX)) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_count   <= '0;
            r_pos     <= macp_pkg::POS_FLAT;
            r_entry   <= '0;
            r_pending <= 1'b0;
        end else if (i_step) begin
            r_sum     <= n_sum;
            r_count   <= n_count;
            r_pos     <= n_pos;
            r_entry   <= n_entry;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/moving_average_crossover_position_unit.sv @@
// channel   dir  payload                                         transfer
// i_in      in   price[31:0], last_bar                           valid & ready
// o_out     out  score[31:0], final_position[1:0], too_short,    valid & ready
//                saturated
// i_cfg     in   window_length[8:0]                              i_cfg_wr_en
//
// one price a cycle while the input is not stalled; the final price passes the input register, then the result register
// store read at transfer, window update and gain when the item leaves the input register
// synchronous active-low reset; no clearing pass over the store
// input stalls only while a final price waits behind an untaken result

`default_nettype none

module moving_average_crossover_position_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [macp_pkg::CFG_W-1:0]  i_cfg_wr_data,
    macp_in_if.sink                          i_in,
    macp_out_if.source                       o_out
);

    logic [macp_pkg::CFG_W-1:0] r_window_length;
    logic [macp_pkg::LEN_W-1:0] len;
    macp_pkg::t_item            in_item;
    macp_pkg::t_item            r_item;
    logic                       r_item_valid;
    logic                       stall;
    logic                       accept;
    logic                       step;
    logic [macp_pkg::PRICE_W-1:0] old_price;
    macp_pkg::t_result          result;
    macp_pkg::t_result          r_out;
    logic                       r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= macp_pkg::CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_window_length <= i_cfg_wr_data;
        end
    end

    assign len = macp_pkg::eff_len(r_window_length);

    assign in_item.price    = i_in.price;
    assign in_item.last_bar = i_in.last_bar;

    assign stall      = r_item_valid && r_item.last_bar && r_out_valid && !o_out.ready;
    assign i_in.ready = !stall;
    assign accept     = i_in.valid && !stall;
    assign step       = r_item_valid && !stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (accept) begin
            r_item_valid <= 1'b1;
        end else if (step) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= in_item;
        end
    end

    macp_window_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (in_item),
        .i_len    (len),
        .o_old    (old_price)
    );

    macp_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_item),
        .i_old    (old_price),
        .i_len    (len),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_item.last_bar) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_item.last_bar) begin
            r_out <= result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.score          = r_out.score;
    assign o_out.final_position = r_out.final_position;
    assign o_out.too_short      = r_out.too_short;
    assign o_out.saturated      = r_out.saturated;

    // a final price leaving the input register raises a result, and a new result only ever comes from one
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_item.last_bar) |=> r_out_valid)
        else $error("final price did not raise a result");

    a_no_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_item_valid && r_item.last_bar))
        else $error("result without a final price");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_item_valid && r_item.last_bar && r_out_valid))
        else $error("input stalled without a waiting result");

    a_short_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.too_short) |->
        (o_out.score == '0 && o_out.final_position == macp_pkg::POS_FLAT &&
         !o_out.saturated))
        else $error("short series result carries a position");

endmodule

`default_nettype wire
